/* design/rbf_pkg.sv */
// Shared constants and types for the Gaussian RBF kernel evaluator.
// No dependencies; compiled first.
package rbf_pkg;

  localparam int DefFeatureWidth = 16;

  localparam int SumW    = 40;   // squared-distance accumulator, Q24.16
  localparam int GainW   = 32;   // gain register, Q8.24
  localparam int KernelW = 16;   // result, Q0.16
  localparam int MagW    = 20;   // largest difference magnitude that is squared exactly

  localparam logic [SumW-1:0]  SumMax    = '1;
  localparam logic [GainW-1:0] GainReset = 32'd16777216;

  // ln2 in Q.32
  localparam logic [31:0] Ln2Q32 = 32'd2977044472;

  // Taylor series of exp(-r): terms 1..SeriesTerms
  localparam int SeriesTerms = 13;
  localparam int TermIdxW    = 4;

  // queue between front and back end
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef logic [SumW-1:0] sum_t;

  typedef struct packed {
    logic [QCntW-1:0] count;
    logic             empty;
  } queue_stat_t;

endpackage

/* design/rbf_if.sv */
// Valid/ready channel interfaces: coordinate items in, kernel results out.
// Depends on rbf_pkg.
interface rbf_in_if #(
  parameter int FeatureWidth = rbf_pkg::DefFeatureWidth
);
  logic                           valid;
  logic                           ready;
  logic signed [FeatureWidth-1:0] left_value;
  logic                           left_valid;
  logic signed [FeatureWidth-1:0] right_value;
  logic                           right_valid;
  logic                           last_element;

  modport source (
    output valid, left_value, left_valid, right_value, right_valid, last_element,
    input  ready
  );
  modport sink (
    input  valid, left_value, left_valid, right_value, right_valid, last_element,
    output ready
  );
endinterface

interface rbf_out_if;
  logic                         valid;
  logic                         ready;
  logic [rbf_pkg::KernelW-1:0]  kernel_value;

  modport source (output valid, kernel_value, input ready);
  modport sink   (input valid, kernel_value, output ready);
endinterface

/* design/gaussian_rbf_kernel_eval.sv */
// Top level of the Gaussian RBF kernel evaluator: gain register, front end,
// queue and back end. Depends on rbf_pkg, rbf_if, rbf_front, rbf_queue, rbf_back.
//
// Streams coordinate pairs of two observations, one transfer per item, and
// returns exp(-gain * sum of squared differences) as unsigned Q0.16 once per
// pair, on the transfer flagged last_element. A coordinate contributes only
// when both of its valid flags are set; a last item with a missing coordinate
// still closes the pair. The distance sum (Q24.16) saturates at all ones;
// gain is 0.5/sigma^2 in Q8.24 and is written through cfg_we_i/cfg_wdata_i;
// the user must write it only while the block is idle, which the block does
// not enforce (reset value 1.0). Rate: the front end takes one coordinate per
// cycle, three pipeline stages (difference, square, accumulate), and stalls
// only when the four-entry queue of finished sums has no room beyond the
// last-flagged items in flight. The back end works one sum at a time around a
// single shared 32x32 multiplier: pop, two partial products, argument, range
// reduction by ln2, then twelve Taylor terms (multiply, byte-per-cycle
// division by the term index, accumulate), then rounding; an argument that
// reaches 16.0 goes straight to rounding and gives zero. Pairs with as many
// coordinates as the back end spends cycles on a sum run at one coordinate per
// cycle while results are taken; shorter pairs are paced by the back end. A
// finished result waits in an output register; the next sum stalls in rounding until it is taken.
module gaussian_rbf_kernel_eval #(
  parameter int FeatureWidth = rbf_pkg::DefFeatureWidth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  rbf_in_if.sink                    item_i,
  rbf_out_if.source                 result_o,
  input  logic                      cfg_we_i,
  input  logic [rbf_pkg::GainW-1:0] cfg_wdata_i
);
  import rbf_pkg::*;

  logic [GainW-1:0] gain_q, gain_d;

  logic        push;
  sum_t        push_data;
  logic        pop;
  sum_t        pop_data;
  queue_stat_t qstat;

  // gain register; the user writes it only between pairs, the block does not enforce this
  assign gain_d = cfg_we_i ? cfg_wdata_i : gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainReset;
    end else begin
      gain_q <= gain_d;
    end
  end

  // front end: masked squared differences, accumulated per pair
  rbf_front #(
    .FeatureWidth (FeatureWidth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // finished sums wait here while the back end is busy
  rbf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (qstat)
  );

  // back end: exponent evaluation and result register
  rbf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .gain_i        (gain_q),
    .entry_valid_i (!qstat.empty),
    .entry_i       (pop_data),
    .pop_o         (pop),
    .result_o      (result_o)
  );

  // the front end's admission check must keep the queue from overflowing
  a_queue_no_overflow: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    push |-> (qstat.count != QCntW'(QueueDepth))
  ) else $error("distance sum pushed into a full queue");

  // the back end only takes a sum that is there
  a_queue_no_underflow: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty
  ) else $error("back end popped an empty queue");

  // a push and a pop in the same cycle leave the fill level unchanged
  a_queue_count_balance: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (push && pop) |=> (qstat.count == $past(qstat.count))
  ) else $error("queue count moved on simultaneous push and pop");

endmodule

/* design/rbf_front.sv */
// Front end: takes coordinate transfers, squares masked differences and
// accumulates them; pushes the finished distance sum into the queue.
// Depends on rbf_pkg and rbf_if.
module rbf_front #(
  parameter int FeatureWidth = rbf_pkg::DefFeatureWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rbf_in_if.sink               item_i,
  input  rbf_pkg::queue_stat_t qstat_i,
  output logic                 push_o,
  output rbf_pkg::sum_t        push_data_o
);
  import rbf_pkg::*;

  // difference width, never below what the saturation check looks at
  localparam int DiffW = (FeatureWidth + 1 > MagW + 1) ? FeatureWidth + 1 : MagW + 1;

  logic accept;

  logic signed [DiffW-1:0] lx, rx, diff;
  logic        [DiffW-1:0] mag;
  logic                    use_both;

  // stage 1: magnitude of difference
  logic            s1_valid_q, s1_valid_d;
  logic            s1_last_q, s1_last_d;
  logic            s1_use_q, s1_use_d;
  logic            s1_sat_q, s1_sat_d;
  logic [MagW-1:0] s1_mag_q, s1_mag_d;

  // stage 2: square
  logic            s2_valid_q, s2_valid_d;
  logic            s2_last_q, s2_last_d;
  sum_t            s2_sq_q, s2_sq_d;

  // stage 3: accumulate
  sum_t            acc_q, acc_d;
  logic [SumW:0]   acc_ext;
  sum_t            acc_sat;

  logic [QCntW:0]  pend;

  // room in the queue for every last-flagged item still in the pipe, plus this one
  always_comb begin
    pend = (QCntW+1)'(s1_valid_q & s1_last_q) + (QCntW+1)'(s2_valid_q & s2_last_q);
  end
  assign item_i.ready = (({1'b0, qstat_i.count} + pend) < (QCntW+1)'(QueueDepth));
  assign accept       = item_i.valid && item_i.ready;

  always_comb begin
    lx       = DiffW'(item_i.left_value);
    rx       = DiffW'(item_i.right_value);
    diff     = lx - rx;
    mag      = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
    use_both = item_i.left_valid && item_i.right_valid;

    s1_valid_d = accept;
    s1_last_d  = item_i.last_element;
    s1_use_d   = use_both;
    s1_sat_d   = use_both && (|mag[DiffW-1:MagW]);
    s1_mag_d   = mag[MagW-1:0];
  end

  always_comb begin
    s2_valid_d = s1_valid_q;
    s2_last_d  = s1_last_q;
    if (s1_sat_q) begin
      s2_sq_d = SumMax;
    end else if (s1_use_q) begin
      s2_sq_d = SumW'(s1_mag_q) * SumW'(s1_mag_q);
    end else begin
      s2_sq_d = '0;
    end
  end

  always_comb begin
    acc_ext     = {1'b0, acc_q} + {1'b0, s2_sq_q};
    acc_sat     = acc_ext[SumW] ? SumMax : acc_ext[SumW-1:0];
    acc_d       = acc_q;
    push_o      = 1'b0;
    push_data_o = acc_sat;
    if (s2_valid_q) begin
      if (s2_last_q) begin
        push_o = 1'b1;
        acc_d  = '0;
      end else begin
        acc_d  = acc_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
      acc_q      <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_last_q <= s1_last_d;
    s1_use_q  <= s1_use_d;
    s1_sat_q  <= s1_sat_d;
    s1_mag_q  <= s1_mag_d;
    s2_last_q <= s2_last_d;
    s2_sq_q   <= s2_sq_d;
  end

endmodule

/* design/rbf_queue.sv */
// Short FIFO of finished distance sums between front and back end.
// Depends on rbf_pkg.
module rbf_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rbf_pkg::sum_t        push_data_i,
  input  logic                 pop_i,
  output rbf_pkg::sum_t        pop_data_o,
  output rbf_pkg::queue_stat_t stat_o
);
  import rbf_pkg::*;

  sum_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o   = mem_q[rd_ptr_q];
  assign stat_o.count = count_q;
  assign stat_o.empty = (count_q == '0);

endmodule

/* design/rbf_back.sv */
// Back end: sequencer around one shared 32x32 multiplier that turns a
// distance sum into exp(-sum*gain) in Q0.16, plus the result register.
// Depends on rbf_pkg and rbf_if.
module rbf_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [rbf_pkg::GainW-1:0]   gain_i,
  input  logic                        entry_valid_i,
  input  rbf_pkg::sum_t               entry_i,
  output logic                        pop_o,
  rbf_out_if.source                   result_o
);
  import rbf_pkg::*;

  typedef enum logic [8:0] {
    StIdle    = 9'b000000001,
    StMulHi   = 9'b000000010,
    StMulLo   = 9'b000000100,
    StArg     = 9'b000001000,
    StReduce  = 9'b000010000,
    StSerMul  = 9'b000100000,
    StSerDiv  = 9'b001000000,
    StSerAcc  = 9'b010000000,
    StRound   = 9'b100000000
  } back_state_e;

  back_state_e state_q, state_d;

  logic [2:0]           step_q, step_d;
  logic [TermIdxW-1:0]  k_q, k_d;
  sum_t                 ent_q, ent_d;
  logic [51:0]          hi_q, hi_d;      // (sum >> 20) * gain
  logic [35:0]          lo_q, lo_d;      // ((sum & 0xFFFFF) * gain) >> 16
  logic                 zero_q, zero_d;  // argument at or past the limit
  logic [35:0]          rem_q, rem_d;    // t in Q.32, reduced mod ln2
  logic [4:0]           n_q, n_d;        // multiples of ln2 taken out
  logic [31:0]          term_q, term_d;
  logic [32:0]          sum_q, sum_d;    // series sum, stays in (0, 2^32]
  logic [31:0]          div_q, div_d;
  logic [31:0]          quot_q, quot_d;
  logic [3:0]           drem_q, drem_d;
  logic                 out_valid_q, out_valid_d;
  logic [KernelW-1:0]   out_value_q, out_value_d;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [56:0] arg;
  logic [35:0] red_cmp;

  // divider: eight quotient bits per cycle, divisor is the term index
  logic [4:0]  pr;
  logic [3:0]  rr;
  logic [7:0]  qbyte;

  // rounding: (e + 2^(15+n)) >> (16+n)
  logic [5:0]         sh;
  logic [39:0]        wide, shifted;
  logic [KernelW-1:0] rounded;

  assign prod = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    rr    = drem_q;
    qbyte = '0;
    pr    = '0;
    for (int i = 0; i < 8; i++) begin
      pr = {rr, div_q[31-i]};
      if (pr >= {1'b0, k_q}) begin
        pr           = pr - {1'b0, k_q};
        qbyte[7-i]   = 1'b1;
      end
      rr = pr[3:0];
    end
  end

  always_comb begin
    sh      = 6'd15 + 6'(n_q);
    wide    = 40'(sum_q) + (40'd1 << sh);
    shifted = wide >> (sh + 6'd1);
    rounded = (|shifted[39:KernelW]) ? '1 : shifted[KernelW-1:0];
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    k_d         = k_q;
    ent_d       = ent_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    zero_d      = zero_q;
    rem_d       = rem_q;
    n_d         = n_q;
    term_d      = term_q;
    sum_d       = sum_q;
    div_d       = div_q;
    quot_d      = quot_q;
    drem_d      = drem_q;
    out_value_d = out_value_q;
    out_valid_d = out_valid_q && !result_o.ready;
    pop_o       = 1'b0;
    mul_a       = '0;
    mul_b       = gain_i;
    arg         = 57'({hi_q, 4'b0000}) + 57'(lo_q);
    red_cmp     = 36'(Ln2Q32) << step_q;

    case (state_q)
      StIdle: begin
        if (entry_valid_i) begin
          pop_o   = 1'b1;
          ent_d   = entry_i;
          zero_d  = 1'b0;
          n_d     = '0;
          state_d = StMulHi;
        end
      end
      StMulHi: begin
        mul_a   = 32'(ent_q[SumW-1:20]);
        hi_d    = prod[51:0];
        state_d = StMulLo;
      end
      StMulLo: begin
        mul_a   = 32'(ent_q[19:0]);
        lo_d    = prod[51:16];
        state_d = StArg;
      end
      StArg: begin
        // argument capped at 16.0: result underflows to zero there
        if (arg >= (57'd1 << 28)) begin
          zero_d  = 1'b1;
          state_d = StRound;
        end else begin
          rem_d   = {arg[27:0], 8'h00};
          step_d  = 3'd4;
          state_d = StReduce;
        end
      end
      StReduce: begin
        // restoring division by ln2, one quotient bit per cycle
        if (rem_q >= red_cmp) begin
          rem_d       = rem_q - red_cmp;
          n_d[step_q] = 1'b1;
        end
        if (step_q == 3'd0) begin
          term_d  = rem_d[31:0];   // first term is r itself
          k_d     = TermIdxW'(2);
          state_d = StSerMul;
        end else begin
          step_d  = step_q - 1'b1;
        end
      end
      StSerMul: begin
        if (k_q == TermIdxW'(2)) begin
          sum_d = (33'd1 << 32) - 33'(rem_q[31:0]);
        end
        mul_a   = term_q;
        mul_b   = rem_q[31:0];
        div_d   = prod[63:32];
        quot_d  = '0;
        drem_d  = '0;
        step_d  = '0;
        state_d = StSerDiv;
      end
      StSerDiv: begin
        drem_d = rr;
        quot_d = {quot_q[23:0], qbyte};
        div_d  = div_q << 8;
        step_d = step_q + 1'b1;
        if (step_q == 3'd3) begin
          state_d = StSerAcc;
        end
      end
      StSerAcc: begin
        term_d = quot_q;
        sum_d  = k_q[0] ? sum_q - 33'(quot_q) : sum_q + 33'(quot_q);
        if (k_q == TermIdxW'(SeriesTerms)) begin
          state_d = StRound;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = StSerMul;
        end
      end
      StRound: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_value_d = zero_q ? '0 : rounded;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q      <= step_d;
    k_q         <= k_d;
    ent_q       <= ent_d;
    hi_q        <= hi_d;
    lo_q        <= lo_d;
    zero_q      <= zero_d;
    rem_q       <= rem_d;
    n_q         <= n_d;
    term_q      <= term_d;
    sum_q       <= sum_d;
    div_q       <= div_d;
    quot_q      <= quot_d;
    drem_q      <= drem_d;
    out_value_q <= out_value_d;
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.kernel_value = out_value_q;

endmodule

/* tb/gaussian_rbf_kernel_eval_tb.sv */
// Self-checking bench for gaussian_rbf_kernel_eval: streams coordinate pairs,
// predicts each kernel value bit-exactly and compares every result transfer.
// Depends on rbf_pkg, rbf_if and the design files; no external inputs.
module gaussian_rbf_kernel_eval_tb;
  import rbf_pkg::*;

  localparam logic [63:0] LnTwo        = 64'd2977044472;  // ln2, Q.32
  localparam logic [63:0] OneQ32       = 64'd1 << 32;
  localparam logic [63:0] ArgCap       = 64'd1 << 28;     // argument 16.0 in Q.24
  localparam int          TaylorTerms  = 13;
  localparam int          WatchLimit   = 2000;   // cycles without any transfer
  localparam int          ChokeCycles  = 400;    // long result hold-off
  localparam int          SettleCycles = 100;    // > back-end time per sum
  localparam int          MaxReports   = 10;

  typedef struct packed {
    logic signed [15:0] left_value;
    logic               left_ok;
    logic signed [15:0] right_value;
    logic               right_ok;
    logic               last;
  } coord_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [GainW-1:0] cfg_wdata_i;

  rbf_in_if #(.FeatureWidth(DefFeatureWidth)) in_bus ();
  rbf_out_if out_bus ();

  gaussian_rbf_kernel_eval #(.FeatureWidth(DefFeatureWidth)) dut (
    .clk_i,
    .rst_ni,
    .item_i     (in_bus),
    .result_o   (out_bus),
    .cfg_we_i,
    .cfg_wdata_i
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // stimulus and prediction state
  coord_t            coords_pending[$];
  logic [KernelW-1:0] expected_kernels[$];
  sum_t              distance_acc = '0;
  logic [GainW-1:0]  gain_shadow  = GainReset;
  coord_t            taken, next_coord;
  logic [KernelW-1:0] want;

  // control shared with the driver and monitor
  logic calm      = 1'b0;   // no idling on either side
  logic choke_req = 1'b0;   // ask the monitor for one long hold-off
  logic choke_done = 1'b0;
  int   send_gap  = 0;
  int   hold_left = 0;
  int   quiet     = 0;
  int   fails     = 0;

  // exp(-norm*gain) in Q0.16.
  // norm is Q.16, gain Q.24; the product is truncated to Q.24 and split as
  // n*ln2 + r. exp(-r) comes from a truncated Taylor series in Q.32, then
  // the 2^-n scaling and round-half-up fold into one shift.
  function automatic logic [KernelW-1:0] kernel_of_norm(input sum_t norm,
                                                        input logic [GainW-1:0] g);
    logic [63:0]        arg, t32, n, r, term, e, rnd;
    logic signed [63:0] acc;
    int                 k;
    arg = ((64'(norm[SumW-1:20]) * 64'(g)) << 4) + ((64'(norm[19:0]) * 64'(g)) >> 16);
    if (arg >= ArgCap) return '0;  // below half an LSB
    t32  = arg << 8;
    n    = t32 / LnTwo;
    r    = t32 - n * LnTwo;
    term = OneQ32;
    acc  = OneQ32;
    for (k = 1; k <= TaylorTerms; k++) begin
      term = ((term * r) >> 32) / 64'(k);
      if (k % 2 == 1) acc = acc - term;
      else            acc = acc + term;
    end
    e   = (acc > 0) ? 64'(acc) : 64'd0;
    rnd = (e + (64'd1 << (15 + n))) >> (16 + n);
    return (rnd > 64'd65535) ? 16'hFFFF : rnd[15:0];  // 1.0 saturates
  endfunction

  // Fold one accepted coordinate into the running distance; a last flag
  // closes the pair and queues its kernel value.
  task automatic fold_coord(input coord_t c);
    logic signed [16:0] diff;
    logic [16:0]        mag;
    logic [SumW:0]      wide;
    if (c.left_ok && c.right_ok) begin
      diff = {c.left_value[15], c.left_value} - {c.right_value[15], c.right_value};
      mag  = diff[16] ? -diff : diff;
      wide = {1'b0, distance_acc} + mag * mag;
      distance_acc = wide[SumW] ? SumMax : wide[SumW-1:0];  // saturate, no wrap
    end
    if (c.last) begin
      expected_kernels.push_back(kernel_of_norm(distance_acc, gain_shadow));
      distance_acc = '0;
    end
  endtask

  function automatic void note_mismatch(input string what, input string exp_s, input int got);
    fails++;
    if (fails <= MaxReports)
      $display("%0t: %s: expected %s, got %0d", $realtime, what, exp_s, got);
  endfunction

  // Driver: one coordinate per transfer; valid only drops after a transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        taken = '{in_bus.left_value, in_bus.left_valid, in_bus.right_value,
                  in_bus.right_valid, in_bus.last_element};
        fold_coord(taken);
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap != 0) begin
          send_gap     <= send_gap - 1;
          in_bus.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
          send_gap     <= $urandom_range(0, 8);  // idle gap of random length
          in_bus.valid <= 1'b0;
        end else if (coords_pending.size() != 0) begin
          next_coord          = coords_pending.pop_front();
          in_bus.valid        <= 1'b1;
          in_bus.left_value   <= next_coord.left_value;
          in_bus.left_valid   <= next_coord.left_ok;
          in_bus.right_value  <= next_coord.right_value;
          in_bus.right_valid  <= next_coord.right_ok;
          in_bus.last_element <= next_coord.last;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest prediction,
  // paces ready, and runs the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_kernels.size() == 0) begin
          note_mismatch("unexpected kernel_value", "nothing", out_bus.kernel_value);
        end else begin
          want = expected_kernels.pop_front();
          if (out_bus.kernel_value !== want)
            note_mismatch("kernel_value", $sformatf("%0d", want), out_bus.kernel_value);
        end
      end

      if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        out_bus.ready <= 1'b0;
      end else if (choke_req && !choke_done) begin
        // long hold-off: the four-entry queue fills and input transfers stop
        hold_left     <= ChokeCycles - 1;
        choke_done    <= 1'b1;
        out_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        hold_left     <= $urandom_range(0, 8);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end

      // only counts while work is outstanding
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (coords_pending.size() == 0 && !in_bus.valid && expected_kernels.size() == 0)) begin
        quiet <= 0;
      end else if (quiet == WatchLimit) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic queue_coord(input logic signed [15:0] lv, input logic lok,
                             input logic signed [15:0] rv, input logic rok,
                             input logic last);
    coords_pending.push_back('{lv, lok, rv, rok, last});
  endtask

  // Coordinate within +-span LSBs; a span of 32767 covers the whole field.
  function automatic logic signed [15:0] pick_coord(input int span);
    if (span >= 32767) return 16'($urandom);
    return 16'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic queue_pair(input int len, input int span);
    int i;
    for (i = 0; i < len; i++)
      queue_coord(pick_coord(span), $urandom_range(0, 7) != 0,
                  pick_coord(span), $urandom_range(0, 7) != 0, i == len - 1);
  endtask

  // Mostly short pairs, some mid-length, a few past the back-end pace.
  task automatic random_pairs(input int target, input bit short_only);
    int sent, len, span, roll;
    sent = 0;
    while (sent < target) begin
      roll = $urandom_range(0, 15);
      if (short_only)     len = $urandom_range(1, 2);
      else if (roll == 0) len = $urandom_range(82, 130);
      else if (roll < 5)  len = $urandom_range(9, 40);
      else                len = $urandom_range(1, 8);
      case ($urandom_range(0, 3))
        0:       span = 64;
        1:       span = 256;
        2:       span = 2048;
        default: span = 32767;
      endcase
      queue_pair(len, span);
      sent += len;
    end
  endtask

  // Wait for every queued coordinate and result, then let the back end drain.
  task automatic settle();
    do @(negedge clk_i);
    while (coords_pending.size() != 0 || in_bus.valid || expected_kernels.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_gain(input logic [GainW-1:0] g);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= g;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    gain_shadow = g;
    @(negedge clk_i);
  endtask

  initial begin
    int               i, p;
    logic [GainW-1:0] g;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    in_bus.valid        = 1'b0;
    in_bus.left_value   = '0;
    in_bus.left_valid   = 1'b0;
    in_bus.right_value  = '0;
    in_bus.right_valid  = 1'b0;
    in_bus.last_element = 1'b0;
    out_bus.ready       = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset gain of 1.0.
    // zero distance rounds to 1.0 and saturates
    queue_coord(16'sh0100, 1'b1, 16'sh0100, 1'b1, 1'b1);
    // full-scale differences: argument far past 16, result zero; then equal extremes, result 1.0
    queue_coord(16'sh8000, 1'b1, 16'sh7FFF, 1'b1, 1'b1);
    queue_coord(16'sh7FFF, 1'b1, 16'sh8000, 1'b1, 1'b1);
    queue_coord(16'sh8000, 1'b1, 16'sh8000, 1'b1, 1'b1);
    queue_coord(16'sh7FFF, 1'b1, 16'sh7FFF, 1'b1, 1'b1);
    // distance 1.0, then a last element with its left value missing
    queue_coord(16'sd256, 1'b1, 16'sd0, 1'b1, 1'b0);
    queue_coord(16'sd5, 1'b0, -16'sd7, 1'b1, 1'b1);
    // masked coordinates mid-pair: right missing, both missing
    queue_coord(-16'sd128, 1'b1, 16'sd0, 1'b1, 1'b0);
    queue_coord(16'sd1000, 1'b1, 16'sd9, 1'b0, 1'b0);
    queue_coord(-16'sd5, 1'b0, 16'sd77, 1'b0, 1'b0);
    queue_coord(16'sd64, 1'b1, 16'sd0, 1'b1, 1'b1);
    // one LSB apart
    queue_coord(16'sd1, 1'b1, 16'sd0, 1'b1, 1'b1);
    // argument exactly 16.0, then just below
    queue_coord(16'sd1024, 1'b1, 16'sd0, 1'b1, 1'b1);
    queue_coord(16'sd0, 1'b1, 16'sd1023, 1'b1, 1'b1);
    // several elements before the last flag
    queue_coord(-16'sd300, 1'b1, 16'sd200, 1'b1, 1'b0);
    queue_coord(16'sd12, 1'b1, -16'sd40, 1'b1, 1'b0);
    queue_coord(16'sd90, 1'b1, 16'sd90, 1'b1, 1'b0);
    queue_coord(-16'sd1, 1'b1, 16'sd1, 1'b1, 1'b1);
    // fully masked last element on an empty sum
    queue_coord(16'sd0, 1'b0, 16'sd0, 1'b0, 1'b1);
    queue_coord(16'sd181, 1'b1, 16'sd0, 1'b1, 1'b1);
    settle();

    // zero gain: every result is the saturated 1.0
    set_gain('0);
    random_pairs(90, 1'b0);
    settle();

    // smallest nonzero gain; a run of full-scale steps saturates the sum,
    // which then maps to an argument near 1.0
    set_gain(32'd1);
    for (i = 0; i < 300; i++)
      queue_coord((i % 2) ? 16'sh8000 : 16'sh7FFF, 1'b1,
                  (i % 2) ? 16'sh7FFF : 16'sh8000, 1'b1, i == 299);
    random_pairs(60, 1'b0);
    settle();

    // largest gain
    set_gain('1);
    random_pairs(90, 1'b0);
    settle();

    for (p = 0; p < 4; p++) begin
      case (p)
        0:       g = $urandom;
        1:       g = $urandom_range(0, 32'h0100_0000);
        2:       g = $urandom_range(0, 32'h0000_4000);
        default: g = $urandom_range(0, 32'h0000_0100);
      endcase
      set_gain(g);
      random_pairs(120, 1'b0);
      settle();
    end

    // back pressure: short pairs keep coming while results are held off
    set_gain(32'h0010_0000);
    choke_req = 1'b1;
    random_pairs(80, 1'b1);
    settle();

    // closing stretch at full rate, reset gain written back
    set_gain(GainReset);
    calm = 1'b1;
    random_pairs(150, 1'b0);
    settle();

    if (fails == 0) $display("PASS");
    else            $display("FAIL");
    $finish;
  end

endmodule
